FILE: rtl/core/rtce_pkg.sv
// Shared types and constants for the RTC date to epoch seconds converter.
package rtce_pkg;

    localparam int unsigned RAW_W   = 8;
    localparam int unsigned EPOCH_W = 34;
    localparam int unsigned YDAY_W  = 14;
    localparam int unsigned ZONE_W  = 5;
    localparam int unsigned CFG_W   = 5;

    localparam logic CFG_ZONE_OFFSET = 1'b0;
    localparam logic CFG_SUMMER_TIME = 1'b1;

    localparam logic signed [ZONE_W-1:0] ZONE_RESET = 5'sd1;

    typedef struct packed {
        logic [RAW_W-1:0] year;
        logic [RAW_W-1:0] month;
        logic [RAW_W-1:0] day;
        logic [RAW_W-1:0] hours;
        logic [RAW_W-1:0] minutes;
        logic [RAW_W-1:0] seconds;
    } clock_fields_t;

    typedef struct packed {
        clock_fields_t fields;
        logic          bcd_error;
    } decoded_t;

endpackage

FILE: rtl/core/rtce_decode.sv
// BCD or binary decoding of the seconds, minutes, hours, day, month and year bytes with bad-nibble flag.
module rtce_decode (
    input  rtce_pkg::clock_fields_t raw,
    input  logic                    binary_mode,
    output rtce_pkg::decoded_t      decoded
);

    logic [5:0] bad;

    function automatic logic [rtce_pkg::RAW_W-1:0] bcd_value(
        input logic [rtce_pkg::RAW_W-1:0] b
    );
        logic [rtce_pkg::RAW_W-1:0] hi;
        logic [rtce_pkg::RAW_W-1:0] lo;
        hi = {4'd0, b[7:4]};
        lo = {4'd0, b[3:0]};
        return (hi << 3) + (hi << 1) + lo;
    endfunction

    function automatic logic nibble_bad(input logic [rtce_pkg::RAW_W-1:0] b);
        return (b[3:0] > 4'd9) || (b[7:4] > 4'd9);
    endfunction

    function automatic logic [rtce_pkg::RAW_W-1:0] decode_byte(
        input logic [rtce_pkg::RAW_W-1:0] b,
        input logic                       is_binary
    );
        logic [rtce_pkg::RAW_W-1:0] r;
        if (is_binary) begin
            r = b;
        end else if (nibble_bad(b)) begin
            r = 8'hFF;
        end else begin
            r = bcd_value(b);
        end
        return r;
    endfunction

    always_comb begin
        bad[0] = nibble_bad(raw.seconds);
        bad[1] = nibble_bad(raw.minutes);
        bad[2] = nibble_bad(raw.hours);
        bad[3] = nibble_bad(raw.day);
        bad[4] = nibble_bad(raw.month);
        bad[5] = nibble_bad(raw.year);
        decoded.fields.seconds = decode_byte(raw.seconds, binary_mode);
        decoded.fields.minutes = decode_byte(raw.minutes, binary_mode);
        decoded.fields.hours   = decode_byte(raw.hours, binary_mode);
        decoded.fields.day     = decode_byte(raw.day, binary_mode);
        decoded.fields.month   = decode_byte(raw.month, binary_mode);
        decoded.fields.year    = decode_byte(raw.year, binary_mode);
        decoded.bcd_error      = !binary_mode && (|bad);
    end

endmodule

FILE: rtl/core/rtce_epoch.sv
// Day of year, leap-year count and seconds since 1970 from decoded fields.
module rtce_epoch (
    input  rtce_pkg::clock_fields_t             dec,
    input  logic signed [rtce_pkg::ZONE_W-1:0]  zone_offset_hours,
    input  logic                                summer_time,
    output logic signed [rtce_pkg::EPOCH_W-1:0] epoch_seconds,
    output logic signed [rtce_pkg::YDAY_W-1:0]  day_of_year
);

    logic [7:0]         years;
    logic               leap;
    logic [6:0]         leaps_before;
    logic signed [14:0] mon_s;
    logic signed [14:0] yday;
    logic [7:0]         mon_m7;
    logic signed [17:0] days;
    logic signed [9:0]  hour_adj;
    logic signed [35:0] sum;

    always_comb begin
        // years since 1970; two-digit years below 70 belong to the 2000s
        if (dec.year >= 8'd70) begin
            years = dec.year - 8'd70;
        end else begin
            years = dec.year + 8'd30;
        end
        // within 1970..2155 only 2100 breaks the four-year rule
        leap         = (years[1:0] == 2'd2) && (years != 8'd130);
        leaps_before = 7'(({1'b0, years} + 9'd1) >> 2) - {6'd0, (years >= 8'd131)};

        mon_s  = $signed({7'd0, dec.month});
        mon_m7 = dec.month - 8'd7;
        yday   = (mon_s - 15'sd1) * 15'sd30;
        if (dec.month > 8'd2) begin
            yday = yday - 15'sd2;
        end
        if (dec.month < 8'd7) begin
            yday = yday + $signed({8'd0, dec.month[7:1]});
        end else if (dec.month == 8'd7) begin
            yday = yday + 15'sd3;
        end else begin
            yday = yday + $signed({8'd0, mon_m7[7:1]}) + 15'sd4;
        end
        yday = yday + $signed({7'd0, dec.day}) - 15'sd1;
        if ((dec.month > 8'd2) && leap) begin
            yday = yday + 15'sd1;
        end

        days = $signed({10'd0, years}) * 18'sd365 + $signed({11'd0, leaps_before})
             + {{3{yday[14]}}, yday};

        hour_adj = $signed({2'd0, dec.hours})
                 - {{5{zone_offset_hours[4]}}, zone_offset_hours}
                 - $signed({9'd0, summer_time});

        sum = {{18{days[17]}}, days} * 36'sd86400
            + {{26{hour_adj[9]}}, hour_adj} * 36'sd3600
            + $signed({28'd0, dec.minutes}) * 36'sd60
            + $signed({28'd0, dec.seconds});

        epoch_seconds = sum[rtce_pkg::EPOCH_W-1:0];
        day_of_year   = yday[rtce_pkg::YDAY_W-1:0];
    end

endmodule

FILE: rtl/core/rtc_date_to_epoch_seconds.sv
// RTC date to epoch seconds converter: stream wrapper, registers and config.
//
// One input transaction carries a snapshot of six raw clock bytes on s_tdata
// (seconds in the lowest byte, then minutes, hours, day, month, year) and
// the binary/BCD mode flag on s_tuser. One output transaction returns the
// seconds since 1970-01-01 00:00 UTC, the zero-based day of year and the BCD
// error flag.
// An accepted transaction is captured in the input register; the decode and
// date arithmetic (a few constant multiplies and a short add tree) sit
// between that register and the result register, which drives m_tvalid. One
// transaction per cycle is sustained while m_tready stays high.
// When the receiver stalls, the result register holds and the input
// register fills; s_tready falls only when both are occupied and m_tready
// is low.
// Configuration writes (zone offset, summer time) take effect at once; the
// user must make them while no transaction is in flight, as the block does not enforce this.
// Reset (aresetn low at a clock edge) empties both registers and sets the
// zone offset to 1 hour and summer time on.
module rtc_date_to_epoch_seconds (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_addr,
    input  logic [rtce_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // raw_seconds, raw_minutes, raw_hours, raw_day, raw_month, raw_year
    input  logic [47:0]                 s_tdata,
    // binary_mode
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // epoch_seconds[33:0], day_of_year[47:34]
    output logic [47:0]                 m_tdata,
    // bcd_error
    output logic                        m_tuser
);

    logic signed [rtce_pkg::ZONE_W-1:0]  zone_reg;
    logic                                summer_reg;
    logic                                in_valid_reg;
    rtce_pkg::clock_fields_t             in_fields_reg;
    logic                                in_binary_reg;
    logic                                out_valid_reg;
    logic [47:0]                         out_data_reg;
    logic                                out_err_reg;
    logic                                out_free;
    logic                                in_accept;
    rtce_pkg::decoded_t                  decoded;
    logic signed [rtce_pkg::EPOCH_W-1:0] epoch_next;
    logic signed [rtce_pkg::YDAY_W-1:0]  yday_next;

    rtce_decode u_decode (
        .raw         (in_fields_reg),
        .binary_mode (in_binary_reg),
        .decoded     (decoded)
    );

    rtce_epoch u_epoch (
        .dec               (decoded.fields),
        .zone_offset_hours (zone_reg),
        .summer_time       (summer_reg),
        .epoch_seconds     (epoch_next),
        .day_of_year       (yday_next)
    );

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_free;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_reg   <= rtce_pkg::ZONE_RESET;
            summer_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                rtce_pkg::CFG_ZONE_OFFSET: zone_reg   <= cfg_wdata[rtce_pkg::ZONE_W-1:0];
                rtce_pkg::CFG_SUMMER_TIME: summer_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_fields_reg <= s_tdata;
            in_binary_reg <= s_tuser;
        end
        if (out_free && in_valid_reg) begin
            out_data_reg <= {yday_next, epoch_next};
            out_err_reg  <= decoded.bcd_error;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

endmodule
